@@ hw/rtl/sufb_pkg.sv @@
`timescale 1ns / 1ps

package sufb_pkg;

   // Outgoing frame length in bytes and the per-channel receive queue depth.
   localparam int FRAME_SIZE  = 32;
   localparam int QUEUE_DEPTH = 64;
   localparam int NUM_CHAN    = 3;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_CHAN * QUEUE_DEPTH);
   localparam int IDX_W  = $clog2(FRAME_SIZE);
   localparam int CNT_W  = $clog2(FRAME_SIZE - 1);
   localparam int POS_W  = $clog2(FRAME_SIZE + 1);

   // The command byte that names UART channel zero; the next two name channels one and two.
   localparam logic [7:0] CMD_BASE = 8'h11;
   localparam logic [7:0] CMD_LAST = 8'h13;

   // Input operation codes.
   localparam logic [1:0] OP_UART_RX  = 2'd0;
   localparam logic [1:0] OP_SPI_BYTE = 2'd1;
   localparam logic [1:0] OP_SPI_END  = 2'd2;

   // Result kinds.
   localparam logic KIND_SPI  = 1'b0;
   localparam logic KIND_UART = 1'b1;

   typedef struct packed {
      logic       hit;
      logic [1:0] port;
   } fwd_type;

endpackage

@@ hw/rtl/sufb_if.sv @@
`timescale 1ns / 1ps

interface sufb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [1:0] channel;
   logic [7:0] data;

   modport source (output valid, output op, output channel, output data, input ready);
   modport sink (input valid, input op, input channel, input data, output ready);
endinterface

interface sufb_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] port;
   logic [7:0] byte_out;
   logic       last;

   modport source (output valid, output kind, output port, output byte_out, output last,
                   input ready);
   modport sink (input valid, input kind, input port, input byte_out, input last,
                 output ready);
endinterface

@@ hw/rtl/sufb_queue_mem.sv @@
`timescale 1ns / 1ps

// Receive byte store for all channels, one write and one registered read per cycle.
module sufb_queue_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [sufb_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   input  logic                        rd_en,
   input  logic [sufb_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                  rd_data
);

   logic [7:0] mem_ff [sufb_pkg::NUM_CHAN * sufb_pkg::QUEUE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sufb_parser.sv @@
`timescale 1ns / 1ps

// Tracks the position, command and length of the incoming SPI frame and
// decides whether the current byte is a data byte to pass on to a UART.
module sufb_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_en,
   input  logic              frame_end,
   input  logic [7:0]        data,
   output sufb_pkg::fwd_type fwd
);

   logic [sufb_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                 cmd_ff, cmd_in;
   logic [7:0]                 len_ff, len_in;
   logic                       in_frame;
   logic                       cmd_ok;

   assign in_frame = 32'(pos_ff) < 32'(sufb_pkg::FRAME_SIZE);

   always_comb begin
      cmd_ok   = cmd_ff inside {[sufb_pkg::CMD_BASE:sufb_pkg::CMD_LAST]};
      fwd.hit  = in_frame && (pos_ff >= sufb_pkg::POS_W'(2)) && cmd_ok
                 && ((32'(pos_ff) - 32'd2) < 32'(len_ff));
      fwd.port = 2'(cmd_ff - sufb_pkg::CMD_BASE);
   end

   always_comb begin
      pos_in = pos_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      if (frame_end) begin
         pos_in = '0;
         cmd_in = '0;
         len_in = '0;
      end else if (byte_en && in_frame) begin
         if (pos_ff == '0) begin
            cmd_in = data;
         end else if (pos_ff == sufb_pkg::POS_W'(1)) begin
            len_in = data;
         end
         pos_in = pos_ff + sufb_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cmd_ff <= '0;
         len_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         cmd_ff <= cmd_in;
         len_ff <= len_in;
      end
   end

endmodule

@@ hw/rtl/spi_uart_frame_bridge.sv @@
`timescale 1ns / 1ps

// Bridge between three UART channels and one SPI link. Each word on req_chan is one
// event: a byte received on a UART channel (op 0), a byte of an incoming SPI frame
// (op 1) or the end of an SPI frame (op 2). UART bytes are queued per channel in a
// shared byte memory and silently dropped when that channel's queue is full. Incoming
// SPI frames are parsed as command, length and data; commands 0x11 to 0x13 send each
// data byte within the length straight to UART channel 0 to 2 as one word on rsp_chan
// with kind 1. A frame-end event clears the parser and sends a full outgoing SPI frame
// of FRAME_SIZE words with kind 0, built from the queue of the channel whose turn it
// is: command, count and up to FRAME_SIZE-2 queued bytes, then zero padding, or all
// zeros when that queue is empty; the turn then moves on to the next channel. The last
// flag marks the final word caused by one event. A frame-end event occupies the block
// while each frame byte in turn goes through a queue memory read and then a load of
// the output register; stalls on rsp_chan add to that. A forwarded byte or frame byte
// sits in an output register, and the next event is only taken once that word is
// taken or being taken on rsp_chan. The queue memory needs no clearing after reset:
// an entry's data is only sent once it was written.
module spi_uart_frame_bridge (
   input  logic        clock,
   input  logic        reset,
   sufb_req_if.sink    req_chan,
   sufb_rsp_if.source  rsp_chan
);

   localparam int PTR_W  = sufb_pkg::PTR_W;
   localparam int FILL_W = sufb_pkg::FILL_W;
   localparam int ADDR_W = sufb_pkg::ADDR_W;
   localparam int IDX_W  = sufb_pkg::IDX_W;
   localparam int CNT_W  = sufb_pkg::CNT_W;

   // Idle takes events; fetch reads the next queue byte; send loads one frame byte.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        turn_ff, turn_in;
   logic [PTR_W-1:0]  head_ff [sufb_pkg::NUM_CHAN];
   logic [PTR_W-1:0]  head_in [sufb_pkg::NUM_CHAN];
   logic [FILL_W-1:0] fill_ff [sufb_pkg::NUM_CHAN];
   logic [FILL_W-1:0] fill_in [sufb_pkg::NUM_CHAN];

   // Output register toward rsp_chan.
   logic       out_valid_ff, out_valid_in;
   logic       out_kind_ff, out_kind_in;
   logic [1:0] out_port_ff, out_port_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_free;
   logic       out_load;

   logic              accept;
   logic              byte_en;
   logic              frame_end;
   sufb_pkg::fwd_type fwd;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   logic [1:0]        rx_ch;
   logic [PTR_W:0]    slot_sum;
   logic [PTR_W-1:0]  slot;
   logic [PTR_W-1:0]  head_next;
   logic              last_pos;
   logic              data_pos;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign byte_en        = accept && (req_chan.op == sufb_pkg::OP_SPI_BYTE);
   assign frame_end      = accept && (req_chan.op == sufb_pkg::OP_SPI_END);
   assign rx_ch          = req_chan.channel;

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.kind     = out_kind_ff;
   assign rsp_chan.port     = out_port_ff;
   assign rsp_chan.byte_out = out_byte_ff;
   assign rsp_chan.last     = out_last_ff;

   sufb_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .frame_end (frame_end),
      .data      (req_chan.data),
      .fwd       (fwd)
   );

   sufb_queue_mem u_queue_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Tail slot of the channel being written: head plus fill, wrapped once.
   always_comb begin
      if (rx_ch < 2'd3) begin
         slot_sum = (PTR_W + 1)'(head_ff[rx_ch]) + (PTR_W + 1)'(fill_ff[rx_ch]);
      end else begin
         slot_sum = '0;
      end
      if (32'(slot_sum) >= 32'(sufb_pkg::QUEUE_DEPTH)) begin
         slot = PTR_W'(32'(slot_sum) - 32'(sufb_pkg::QUEUE_DEPTH));
      end else begin
         slot = PTR_W'(slot_sum);
      end
      wr_addr = ADDR_W'(32'(rx_ch) * 32'(sufb_pkg::QUEUE_DEPTH) + 32'(slot));
      rd_addr = ADDR_W'(32'(turn_ff) * 32'(sufb_pkg::QUEUE_DEPTH) + 32'(head_ff[turn_ff]));
      if (32'(head_ff[turn_ff]) + 32'd1 == 32'(sufb_pkg::QUEUE_DEPTH)) begin
         head_next = '0;
      end else begin
         head_next = head_ff[turn_ff] + PTR_W'(1);
      end
      last_pos = 32'(idx_ff) == 32'(sufb_pkg::FRAME_SIZE - 1);
      data_pos = (idx_ff >= IDX_W'(2)) && (32'(idx_ff) < 32'(cnt_ff) + 32'd2);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      turn_in      = turn_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_kind_in  = out_kind_ff;
      out_port_in  = out_port_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_load     = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.op)
                  sufb_pkg::OP_UART_RX: begin
                     if (rx_ch < 2'd3
                         && 32'(fill_ff[rx_ch]) < 32'(sufb_pkg::QUEUE_DEPTH)) begin
                        wr_en          = 1'b1;
                        fill_in[rx_ch] = fill_ff[rx_ch] + FILL_W'(1);
                     end
                  end
                  sufb_pkg::OP_SPI_BYTE: begin
                     if (fwd.hit) begin
                        out_load     = 1'b1;
                        out_valid_in = 1'b1;
                        out_kind_in  = sufb_pkg::KIND_UART;
                        out_port_in  = fwd.port;
                        out_byte_in  = req_chan.data;
                        out_last_in  = 1'b1;
                     end
                  end
                  sufb_pkg::OP_SPI_END: begin
                     // Bytes to take out of the queue for this frame.
                     if (32'(fill_ff[turn_ff]) < 32'(sufb_pkg::FRAME_SIZE - 2)) begin
                        cnt_in = CNT_W'(fill_ff[turn_ff]);
                     end else begin
                        cnt_in = CNT_W'(sufb_pkg::FRAME_SIZE - 2);
                     end
                     idx_in   = '0;
                     state_in = ST_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               out_kind_in  = sufb_pkg::KIND_SPI;
               out_port_in  = '0;
               out_last_in  = last_pos;
               out_byte_in  = '0;
               if (cnt_ff != '0) begin
                  if (idx_ff == '0) begin
                     out_byte_in = sufb_pkg::CMD_BASE + 8'(turn_ff);
                  end else if (idx_ff == IDX_W'(1)) begin
                     out_byte_in = 8'(cnt_ff);
                  end else if (data_pos) begin
                     out_byte_in      = rd_data;
                     head_in[turn_ff] = head_next;
                  end
               end
               if (last_pos) begin
                  fill_in[turn_ff] = fill_ff[turn_ff] - FILL_W'(cnt_ff);
                  turn_in          = (turn_ff == 2'd2) ? 2'd0 : turn_ff + 2'd1;
                  state_in         = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         turn_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < sufb_pkg::NUM_CHAN; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         turn_ff      <= turn_in;
         out_valid_ff <= out_valid_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      out_kind_ff <= out_kind_in;
      out_port_ff <= out_port_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // A queue never holds more bytes than its depth.
   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff[0]) <= 32'(sufb_pkg::QUEUE_DEPTH)
      && 32'(fill_ff[1]) <= 32'(sufb_pkg::QUEUE_DEPTH)
      && 32'(fill_ff[2]) <= 32'(sufb_pkg::QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   // The round-robin turn only names existing channels.
   assert property (@(posedge clock) disable iff (reset) turn_ff != 2'd3)
      else $error("turn names a channel that does not exist");

   // A frame byte is only sent right after the memory read that feeds it, or while stalled.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> ($past(state_ff) == ST_FETCH || $past(state_ff) == ST_SEND))
      else $error("frame byte sent without a preceding queue read");

   // The final frame byte returns the block to idle and moves the turn on.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && out_load && last_pos)
      |=> (state_ff == ST_IDLE && turn_ff != $past(turn_ff)))
      else $error("frame end did not release the block or advance the turn");

   // Events are never taken while a frame is being sent.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept)
      else $error("event accepted during frame send");

endmodule

@@ sim/sufb_result_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the bridge. Every accepted request word updates a private
// copy of the bridge state and queues the words that the bridge should send back.
// Every accepted response word is compared with the oldest queued one.
module sufb_result_checker (
   input  logic        clock,
   input  logic        reset,
   sufb_req_if         req_mon,
   sufb_rsp_if         rsp_mon,
   output int unsigned mismatches,
   output int unsigned pending_count
);

   typedef struct packed {
      logic       kind;
      logic [1:0] port;
      logic [7:0] byte_out;
      logic       last;
   } bridge_word_type;

   bridge_word_type pending_bridge_words[$];

   logic [7:0]                  rx_bytes [sufb_pkg::NUM_CHAN][sufb_pkg::QUEUE_DEPTH];
   logic [sufb_pkg::PTR_W-1:0]  rd_head [sufb_pkg::NUM_CHAN];
   logic [sufb_pkg::FILL_W-1:0] held [sufb_pkg::NUM_CHAN];
   logic [1:0]                  rr_turn;
   logic [sufb_pkg::POS_W-1:0]  frame_pos;
   logic [7:0]                  frame_cmd;
   logic [7:0]                  frame_len;

   task automatic predict_bridge_words(input logic [1:0] op, input logic [1:0] chan,
                                       input logic [7:0] data);
      int              slot;
      int              sent;
      int              fill_now;
      logic [7:0]      value;
      logic [7:0]      cmd_offset;
      bridge_word_type word;
      case (op)
         sufb_pkg::OP_UART_RX: begin
            if (chan < sufb_pkg::NUM_CHAN && held[chan] < sufb_pkg::QUEUE_DEPTH) begin
               slot = (int'(rd_head[chan]) + int'(held[chan])) % sufb_pkg::QUEUE_DEPTH;
               rx_bytes[chan][slot] = data;
               held[chan] = held[chan] + 1'b1;
            end
         end
         sufb_pkg::OP_SPI_BYTE: begin
            // Bytes past the frame size are dropped and the position stays saturated.
            if (frame_pos < sufb_pkg::FRAME_SIZE) begin
               if (frame_pos == 0) begin
                  frame_cmd = data;
               end else if (frame_pos == 1) begin
                  frame_len = data;
               end else if (frame_cmd >= sufb_pkg::CMD_BASE
                            && frame_cmd <= sufb_pkg::CMD_LAST
                            && int'(frame_pos) - 2 < int'(frame_len)) begin
                  cmd_offset = frame_cmd - sufb_pkg::CMD_BASE;
                  word = '{kind: sufb_pkg::KIND_UART, port: cmd_offset[1:0],
                           byte_out: data, last: 1'b1};
                  pending_bridge_words.push_back(word);
               end
               frame_pos = frame_pos + 1'b1;
            end
         end
         sufb_pkg::OP_SPI_END: begin
            frame_pos = '0;
            frame_cmd = '0;
            frame_len = '0;
            fill_now  = int'(held[rr_turn]);
            sent      = (fill_now < sufb_pkg::FRAME_SIZE - 2) ? fill_now
                                                              : sufb_pkg::FRAME_SIZE - 2;
            for (int i = 0; i < sufb_pkg::FRAME_SIZE; i++) begin
               value = 8'h00;
               if (fill_now != 0) begin
                  if (i == 0) begin
                     value = sufb_pkg::CMD_BASE + rr_turn;
                  end else if (i == 1) begin
                     value = 8'(sent);
                  end else if (i - 2 < sent) begin
                     value = rx_bytes[rr_turn][rd_head[rr_turn]];
                     rd_head[rr_turn] = sufb_pkg::PTR_W'((int'(rd_head[rr_turn]) + 1)
                                                         % sufb_pkg::QUEUE_DEPTH);
                  end
               end
               word = '{kind: sufb_pkg::KIND_SPI, port: 2'd0, byte_out: value,
                        last: (i == sufb_pkg::FRAME_SIZE - 1)};
               pending_bridge_words.push_back(word);
            end
            held[rr_turn] = sufb_pkg::FILL_W'(fill_now - sent);
            rr_turn = (rr_turn == sufb_pkg::NUM_CHAN - 1) ? 2'd0 : rr_turn + 2'd1;
         end
         default: begin
         end
      endcase
   endtask

   task automatic compare_word(input bridge_word_type got);
      bridge_word_type want;
      if (pending_bridge_words.size() == 0) begin
         $display("%0t: expected no word, actual kind=%0d port=%0d byte=%02h last=%0d",
                  $time, got.kind, got.port, got.byte_out, got.last);
         mismatches++;
      end else begin
         want = pending_bridge_words.pop_front();
         if (got != want) begin
            if (got.kind != want.kind)
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            if (got.port != want.port)
               $display("%0t: port expected %0d actual %0d", $time, want.port, got.port);
            if (got.byte_out != want.byte_out)
               $display("%0t: byte expected %02h actual %02h", $time, want.byte_out,
                        got.byte_out);
            if (got.last != want.last)
               $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_bridge_words.delete();
         for (int c = 0; c < sufb_pkg::NUM_CHAN; c++) begin
            rd_head[c] = '0;
            held[c]    = '0;
         end
         rr_turn   = 2'd0;
         frame_pos = '0;
         frame_cmd = '0;
         frame_len = '0;
      end else begin
         // A response word can never belong to a request taken at the same edge, so
         // the order of these two steps does not matter.
         if (req_mon.valid && req_mon.ready)
            predict_bridge_words(req_mon.op, req_mon.channel, req_mon.data);
         if (rsp_mon.valid && rsp_mon.ready)
            compare_word('{kind: rsp_mon.kind, port: rsp_mon.port,
                           byte_out: rsp_mon.byte_out, last: rsp_mon.last});
      end
      pending_count = pending_bridge_words.size();
   end

endmodule

@@ sim/tb_spi_uart_frame_bridge.sv @@
`timescale 1ns / 1ps

// Top of the bridge testbench. It makes the clock, the reset and the request words,
// drives the ready of the response channel and gives the verdict. All prediction and
// comparison lives in the result checker beside the bridge.
module tb_spi_uart_frame_bridge;

   // Codes that the bridge ignores: the unused operation and the fourth channel.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] BAD_CHAN  = 2'd3;

   localparam int ITEM_GOAL    = 460;
   localparam int DRAIN_CYCLES = 4 * sufb_pkg::FRAME_SIZE + 100;

   // The receiver holds off completely in one window; in another window neither side
   // idles at all.
   localparam int HOLD_START  = 600;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_START = 1200;
   localparam int QUIET_END   = 1700;

   logic        clock;
   logic        reset;
   int unsigned cycle_no;
   int unsigned counted_items;
   int unsigned mismatches;
   int unsigned pending_count;

   sufb_req_if req_if ();
   sufb_rsp_if rsp_if ();

   spi_uart_frame_bridge dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   sufb_result_checker u_result_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .mismatches    (mismatches),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The cycle count starts from zero, the initial value of a two-state variable.
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   // Generous upper bound on the run. The slowest correct run, with every response
   // word waiting out long stalls, stays well below this.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic bit quiet_window();
      return cycle_no >= QUIET_START && cycle_no < QUIET_END;
   endfunction

   // The response side keeps its own cycle count. During the long hold-off the bridge
   // has stalled its request side, which the sender keeps offering words to.
   initial begin
      int unsigned rx_cycle;
      rx_cycle = 0;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            rsp_if.ready <= 1'b0;
         else if (quiet_window())
            rsp_if.ready <= 1'b1;
         else
            rsp_if.ready <= ($urandom_range(99) >= 25);
         rx_cycle++;
         @(posedge clock);
      end
   end

   // Sends one request word, with random idle cycles in front of it, and returns at
   // the edge where the bridge took it. Words that the bridge ignores are not counted.
   task automatic send_word(input logic [1:0] op, input logic [1:0] chan,
                            input logic [7:0] data);
      while (!quiet_window() && $urandom_range(99) < 25) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.op      <= op;
      req_if.channel <= chan;
      req_if.data    <= data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (op != OP_UNUSED && !(op == sufb_pkg::OP_UART_RX && chan == BAD_CHAN))
         counted_items++;
   endtask

   task automatic send_uart_burst(input logic [1:0] chan, input int count);
      for (int i = 0; i < count; i++)
         send_word(sufb_pkg::OP_UART_RX, chan, 8'($urandom_range(255)));
   endtask

   // An incoming SPI frame: command, length, then the given number of data bytes.
   task automatic send_spi_frame(input logic [7:0] cmd, input logic [7:0] len,
                                 input int data_count);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, cmd);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, len);
      for (int i = 0; i < data_count; i++)
         send_word(sufb_pkg::OP_SPI_BYTE, 2'($urandom_range(3)), 8'($urandom_range(255)));
   endtask

   initial begin
      int         pick;
      int         data_count;
      logic [7:0] cmd;
      logic [7:0] len;

      counted_items  = 0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.op      = sufb_pkg::OP_UART_RX;
      req_if.channel = 2'd0;
      req_if.data    = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A frame end on an empty queue gives a frame of zeros.
      send_word(sufb_pkg::OP_SPI_END, 2'd0, 8'h00);
      send_word(sufb_pkg::OP_UART_RX, 2'd0, 8'h00);
      send_word(sufb_pkg::OP_UART_RX, 2'd1, 8'hFF);
      send_word(sufb_pkg::OP_UART_RX, 2'd2, 8'hA5);
      // The fourth channel and the unused operation must not disturb anything.
      send_word(sufb_pkg::OP_UART_RX, BAD_CHAN, 8'h5A);
      send_word(OP_UNUSED, 2'd3, 8'hFF);
      // Two bytes forwarded to UART one, then a byte past the length that is dropped.
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, sufb_pkg::CMD_BASE + 8'd1);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, 8'd2);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, 8'hFF);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, 8'h00);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, 8'h77);
      send_word(sufb_pkg::OP_SPI_END, 2'd0, 8'h00);
      // An unknown command forwards nothing.
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, sufb_pkg::CMD_LAST + 8'd1);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, 8'd5);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, 8'h33);
      send_word(sufb_pkg::OP_SPI_END, 2'd0, 8'h00);
      // A zero length forwards nothing either.
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, sufb_pkg::CMD_BASE);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, 8'd0);
      send_word(sufb_pkg::OP_SPI_BYTE, 2'd0, 8'h44);
      send_word(sufb_pkg::OP_SPI_END, 2'd0, 8'h00);
      // An overlong frame with the largest length: only FRAME_SIZE-2 bytes go out.
      send_spi_frame(sufb_pkg::CMD_LAST, 8'hFF, sufb_pkg::FRAME_SIZE + 2);
      send_word(sufb_pkg::OP_SPI_END, 2'd0, 8'h00);

      // Random part: mostly well-formed frames and UART bursts with random content,
      // with now and then a burst long enough to overflow a queue, and some noise.
      while (counted_items < ITEM_GOAL) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            if ($urandom_range(19) == 0)
               send_uart_burst(2'($urandom_range(2)), sufb_pkg::QUEUE_DEPTH + 6);
            else if ($urandom_range(15) == 0)
               send_uart_burst(BAD_CHAN, $urandom_range(1, 3));
            else
               send_uart_burst(2'($urandom_range(2)), $urandom_range(1, 8));
         end else if (pick < 70) begin
            if ($urandom_range(7) == 0)
               cmd = 8'($urandom_range(255));
            else
               cmd = sufb_pkg::CMD_BASE + 8'($urandom_range(2));
            if ($urandom_range(9) == 0)
               len = 8'hFF;
            else
               len = 8'($urandom_range(sufb_pkg::FRAME_SIZE + 2));
            if ($urandom_range(4) == 0)
               data_count = $urandom_range(sufb_pkg::FRAME_SIZE + 2);
            else
               data_count = (len > sufb_pkg::FRAME_SIZE) ? sufb_pkg::FRAME_SIZE
                                                         : int'(len);
            send_spi_frame(cmd, len, data_count);
            if ($urandom_range(3) != 0)
               send_word(sufb_pkg::OP_SPI_END, 2'd0, 8'h00);
         end else if (pick < 88) begin
            send_word(sufb_pkg::OP_SPI_END, 2'($urandom_range(3)), 8'($urandom_range(255)));
         end else begin
            send_word(2'($urandom_range(3)), 2'($urandom_range(3)),
                      8'($urandom_range(255)));
         end
      end
      req_if.valid <= 1'b0;

      // Wait for every predicted word, then give a late stray word time to show up.
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
